>>> design/lldq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the linked-list deque manager.
// No dependencies; used by lldq_core and linked_list_deque_manager.
package lldq_pkg;

  // Field widths of the streaming items
  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int HANDLE_W = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Packed stream widths (tdata rounded up to whole bytes)
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 48;

  // Request codes
  localparam logic [FUNC_W-1:0] FUNC_INS_HEAD = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_INS_TAIL = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_RM_HEAD  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_RM_TAIL  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_RM_HNDL  = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]          func;
    logic signed [VALUE_W-1:0]  value;
    logic [HANDLE_W-1:0]        handle;
  } lldq_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  removed_value;
    logic [HANDLE_W-1:0]        new_handle;
    logic [COUNT_W-1:0]         count;
  } lldq_res_t;

endpackage

>>> design/lldq_core.sv
`timescale 1ns / 1ps
// List state and single-pass update: link arrays, data store, in-use flags,
// free-slot stack, head/tail/count registers. Depends on lldq_pkg.
module lldq_core #(
  parameter int POOL_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  lldq_pkg::lldq_req_t req_i,
  output lldq_pkg::lldq_res_t res_o
);

  localparam int SW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int LW = $clog2(POOL_DEPTH + 1);
  localparam int HW = lldq_pkg::HANDLE_W;
  localparam int CW = lldq_pkg::COUNT_W;
  localparam logic [LW-1:0] SENT = LW'(POOL_DEPTH);

  // Link entries of the pool slots; the sentinel lives in head_q / tail_q
  logic [LW-1:0]                    next_q [POOL_DEPTH];
  logic [LW-1:0]                    prev_q [POOL_DEPTH];
  logic signed [lldq_pkg::VALUE_W-1:0] data_q [POOL_DEPTH];
  logic [POOL_DEPTH-1:0]            in_use_q;
  logic [SW-1:0]                    stack_q [POOL_DEPTH];
  logic [LW-1:0]                    free_top_q;
  logic [LW-1:0]                    count_q;
  logic [LW-1:0]                    head_q;
  logic [LW-1:0]                    tail_q;

  logic          is_ins, is_ins_head, is_rm_end, is_rm_hndl;
  logic          ins_ok, rem_ok, do_ins, do_rem;
  logic [SW-1:0] top_idx, alloc_idx;
  logic [LW-1:0] alloc_link;
  logic [LW-1:0] end_link;
  logic          handle_ok;
  logic [SW-1:0] hndl_idx, rem_idx;
  logic [LW-1:0] nb_prev, nb_next;
  logic [LW-1:0] count_d;
  logic [lldq_pkg::STATUS_W-1:0] status;

  // Decode and checks
  always_comb begin
    is_ins      = (req_i.func == lldq_pkg::FUNC_INS_HEAD) ||
                  (req_i.func == lldq_pkg::FUNC_INS_TAIL);
    is_ins_head = (req_i.func == lldq_pkg::FUNC_INS_HEAD);
    is_rm_end   = (req_i.func == lldq_pkg::FUNC_RM_HEAD) ||
                  (req_i.func == lldq_pkg::FUNC_RM_TAIL);
    is_rm_hndl  = (req_i.func == lldq_pkg::FUNC_RM_HNDL);

    top_idx    = SW'(free_top_q - 1'b1);
    alloc_idx  = stack_q[top_idx];
    alloc_link = LW'(alloc_idx);

    end_link  = (req_i.func == lldq_pkg::FUNC_RM_HEAD) ? head_q : tail_q;
    handle_ok = (32'(req_i.handle) < 32'(POOL_DEPTH));
    hndl_idx  = SW'(req_i.handle);
    rem_idx   = is_rm_hndl ? hndl_idx : SW'(end_link);
    nb_prev   = prev_q[rem_idx];
    nb_next   = next_q[rem_idx];

    ins_ok = is_ins && (free_top_q != '0);
    rem_ok = (is_rm_end && (count_q != '0) && (end_link < SENT)) ||
             (is_rm_hndl && (count_q != '0) && handle_ok && in_use_q[hndl_idx]);
    do_ins = req_valid_i && ins_ok;
    do_rem = req_valid_i && rem_ok;

    status = lldq_pkg::ST_OK;
    if (is_ins && !ins_ok) begin
      status = lldq_pkg::ST_FULL;
    end else if ((is_rm_end || is_rm_hndl) && (count_q == '0)) begin
      status = lldq_pkg::ST_EMPTY;
    end else if (is_rm_end && !rem_ok) begin
      status = lldq_pkg::ST_EMPTY;
    end else if (is_rm_hndl && !rem_ok) begin
      status = lldq_pkg::ST_BAD_HANDLE;
    end

    count_d = count_q;
    if (ins_ok) begin
      count_d = count_q + 1'b1;
    end else if (rem_ok && (count_q != '0)) begin
      count_d = count_q - 1'b1;
    end

    res_o.status        = status;
    res_o.removed_value = rem_ok ? data_q[rem_idx] : '0;
    res_o.new_handle    = ins_ok ? HW'(alloc_idx) : '0;
    res_o.count         = CW'(count_d);
  end

  // Link and data stores, no reset: only read for slots in use
  always_ff @(posedge clk_i) begin
    if (do_ins) begin
      data_q[alloc_idx] <= req_i.value;
      next_q[alloc_idx] <= is_ins_head ? head_q : SENT;
      prev_q[alloc_idx] <= is_ins_head ? SENT : tail_q;
      if (is_ins_head && (head_q != SENT)) begin
        prev_q[SW'(head_q)] <= alloc_link;
      end
      if (!is_ins_head && (tail_q != SENT)) begin
        next_q[SW'(tail_q)] <= alloc_link;
      end
    end else if (do_rem) begin
      if (nb_prev != SENT) begin
        next_q[SW'(nb_prev)] <= nb_next;
      end
      if (nb_next != SENT) begin
        prev_q[SW'(nb_next)] <= nb_prev;
      end
    end
  end

  // Sentinel links, flags, free stack and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= SENT;
      tail_q     <= SENT;
      count_q    <= '0;
      free_top_q <= LW'(POOL_DEPTH);
      in_use_q   <= '0;
      for (int i = 0; i < POOL_DEPTH; i++) begin
        stack_q[i] <= SW'(POOL_DEPTH - 1 - i);
      end
    end else if (do_ins) begin
      in_use_q[alloc_idx] <= 1'b1;
      free_top_q          <= free_top_q - 1'b1;
      count_q             <= count_d;
      if (is_ins_head) begin
        head_q <= alloc_link;
        if (tail_q == SENT) tail_q <= alloc_link;
      end else begin
        tail_q <= alloc_link;
        if (head_q == SENT) head_q <= alloc_link;
      end
    end else if (do_rem) begin
      in_use_q[rem_idx] <= 1'b0;
      count_q           <= count_d;
      if (nb_prev == SENT) head_q <= nb_next;
      if (nb_next == SENT) tail_q <= nb_prev;
      if (free_top_q < LW'(POOL_DEPTH)) begin
        stack_q[SW'(free_top_q)] <= rem_idx;
        free_top_q               <= free_top_q + 1'b1;
      end
    end
  end

  // Every slot is either on the list or on the free stack
  a_pool_conserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(count_q) + 32'(free_top_q)) == 32'(POOL_DEPTH))
    else $error("slot count and free stack disagree");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) == (head_q == SENT))
    else $error("head link inconsistent with count");

  a_empty_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) == (tail_q == SENT))
    else $error("tail link inconsistent with count");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_ins |=> (count_q == LW'($past(count_q) + 1'b1)))
    else $error("insert did not bump count");

  a_rem_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_rem |=> !in_use_q[$past(rem_idx)])
    else $error("removed slot still marked in use");

  // The sentinel never appears as a stored slot number
  a_alloc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_ins |-> (alloc_link < SENT))
    else $error("allocated slot out of pool");

endmodule

>>> design/linked_list_deque_manager.sv
`timescale 1ns / 1ps
// Top level of the linked-list deque manager: stream ports, request register
// and result register around lldq_core. Depends on lldq_pkg and lldq_core.
//
// Usage: each request item on the s_axis channel names an operation in tuser
// (insert at head, insert at tail, remove head, remove tail, remove by handle)
// with the data word and handle in tdata. Every request yields exactly one
// result item on m_axis: status in tuser, removed word, allocated handle and
// the element count after the request in tdata.
// Timing: a request taken into the request register is processed as it moves
// into the result register, and its result is valid from then on.
// Throughput: one item per cycle while m_axis_tready_i is high; the whole list
// update is a single pass of logic between the request register and the result
// register, so the rate is set by that one register-to-register path.
// Reset: the list is empty, all POOL_DEPTH slots are free and slot 0 is
// handed out first. No clearing pass is needed; both channels go idle.
// Stall: when m_axis_tready_i is low the result holds; one further request
// waits in the request register, after which s_axis_tready_o drops.
module linked_list_deque_manager #(
  parameter int POOL_DEPTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [31:0] value, [35:32] handle, [39:36] zero
  input  logic [lldq_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // [2:0] func
  input  logic [lldq_pkg::FUNC_W-1:0]     s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [31:0] removed_value, [35:32] new_handle, [40:36] count, [47:41] zero
  output logic [lldq_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  // [1:0] status
  output logic [lldq_pkg::STATUS_W-1:0]   m_axis_tuser_o
);

  localparam int VW = lldq_pkg::VALUE_W;
  localparam int HW = lldq_pkg::HANDLE_W;
  localparam int CW = lldq_pkg::COUNT_W;

  logic                in_valid_q;
  lldq_pkg::lldq_req_t req_q;
  logic                out_valid_q;
  lldq_pkg::lldq_res_t res_q;
  lldq_pkg::lldq_res_t res_d;
  logic                s_take;
  logic                advance;

  // Handshake: the request register drains into the result register
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_take          = s_axis_tvalid_i && s_axis_tready_o;

  lldq_core #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (advance),
    .req_i       (req_q),
    .res_o       (res_d)
  );

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_take) begin
      req_q.func   <= s_axis_tuser_i;
      req_q.value  <= s_axis_tdata_i[VW-1:0];
      req_q.handle <= s_axis_tdata_i[VW+HW-1:VW];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = res_q.status;
  assign m_axis_tdata_o  = {{(lldq_pkg::M_TDATA_W - VW - HW - CW){1'b0}},
                            res_q.count, res_q.new_handle, res_q.removed_value};

endmodule
